### rtl/page_table_lru_frame_manager_defines.svh
// Assertion macros shared by the page table frame manager sources.
// Needs nothing else; included by the files that assert.
`ifndef PAGE_TABLE_LRU_FRAME_MANAGER_DEFINES_SVH
`define PAGE_TABLE_LRU_FRAME_MANAGER_DEFINES_SVH

// condition in the same cycle
`define PTLRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptlru assertion failed");

// condition in the cycle after the antecedent
`define PTLRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptlru assertion failed");

`endif

### rtl/ptlru_pkg.sv
// Types, constants and codes for the page table frame manager.
// No dependencies.
package ptlru_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 14;
    localparam int VIRT_PAGES = 1 << PAGE_W;
    localparam int FRAME_W    = 8;
    localparam int FRAMES     = 1 << FRAME_W;
    localparam int CNT_W      = FRAME_W + 1;
    localparam int ENT_W      = FRAME_W + 2;
    localparam int STAT_W     = 32;

    // entry bit positions
    localparam int ENT_PRES  = FRAME_W;
    localparam int ENT_DIRTY = FRAME_W + 1;

    localparam logic [2:0] FN_LOOKUP = 3'd0;
    localparam logic [2:0] FN_MAP    = 3'd1;
    localparam logic [2:0] FN_DIRTY  = 3'd2;
    localparam logic [2:0] FN_FREE   = 3'd3;
    localparam logic [2:0] FN_VICTIM = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAULT   = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NOFRAME = 2'd3;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_TRD, S_TCMP, S_TAPP,
        S_VSEL, S_PRD, S_PCHK, S_OUT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] addr;
        logic [ENT_W-1:0]  wdata;
    } t_tbl_port;

    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] addr;
        logic [FRAME_W-1:0] wdata;
    } t_rec_port;

endpackage

### rtl/ptlru_if.sv
// Request and response channel interfaces of the frame manager.
// Depends on ptlru_pkg.
interface ptlru_req_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     func;
    logic [ptlru_pkg::ADDR_W-1:0]   address;
    logic [ptlru_pkg::FRAME_W-1:0]  frame;
    modport source (output valid, func, address, frame, input ready);
    modport sink (input valid, func, address, frame, output ready);
endinterface

interface ptlru_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ptlru_pkg::FRAME_W-1:0]  frame_out;
    logic [1:0]                     status;
    logic [ptlru_pkg::STAT_W-1:0]   total_accesses;
    logic [ptlru_pkg::STAT_W-1:0]   fault_count;
    logic [ptlru_pkg::STAT_W-1:0]   dirty_fault_count;
    modport source (output valid, frame_out, status, total_accesses, fault_count,
                    dirty_fault_count, input ready);
    modport sink (input valid, frame_out, status, total_accesses, fault_count,
                  dirty_fault_count, output ready);
endinterface

### rtl/ptlru_ram.sv
// Single-port synchronous RAM with registered read.
// No dependencies.
module ptlru_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ptlru_ctrl.sv
// Request sequencer: table clear, lookups, recency list walk, victim scan.
// Depends on ptlru_pkg, ptlru_if and the defines header.
`include "page_table_lru_frame_manager_defines.svh"

module ptlru_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptlru_req_if.sink                     i_req,
    ptlru_rsp_if.source                   o_rsp,
    input  logic [ptlru_pkg::ENT_W-1:0]   i_tbl_rdata,
    input  logic [ptlru_pkg::FRAME_W-1:0] i_rec_rdata,
    output ptlru_pkg::t_tbl_port          o_tbl,
    output ptlru_pkg::t_rec_port          o_rec
);
    localparam int FW = ptlru_pkg::FRAME_W;
    localparam int PW = ptlru_pkg::PAGE_W;
    localparam int CW = ptlru_pkg::CNT_W;
    localparam int SW = ptlru_pkg::STAT_W;

    ptlru_pkg::t_state r_state, n_state;
    logic [2:0]    r_func;
    logic [PW-1:0] r_p, n_p;
    logic [FW-1:0] r_frame, r_tf, n_tf, r_carry, n_carry, r_i, n_i, r_fo, n_fo;
    logic [1:0]    r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt, r_nff, n_nff;
    logic [SW-1:0] r_acc, n_acc, r_flt, n_flt, r_dflt, n_dflt;
    logic          r_ovld, n_ovld;
    logic [FW-1:0] r_ofr, n_ofr;
    logic [1:0]    r_ost, n_ost;
    logic [SW-1:0] r_oacc, n_oacc, r_oflt, n_oflt, r_odflt, n_odflt;

    logic          acc;
    logic          in_rng;
    logic          ent_pres, ent_dirty;
    logic          last_pos;

    assign acc       = i_req.valid && i_req.ready;
    assign in_rng    = i_req.address[ptlru_pkg::ADDR_W-1:ptlru_pkg::PAGE_SHIFT+PW] == '0;
    assign ent_pres  = i_tbl_rdata[ptlru_pkg::ENT_PRES];
    assign ent_dirty = i_tbl_rdata[ptlru_pkg::ENT_DIRTY];
    assign last_pos  = {1'b0, r_i} == r_cnt - CW'(1);

    assign i_req.ready = r_state == ptlru_pkg::S_IDLE;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptlru_pkg::S_CLR: begin
                if (r_p == PW'(ptlru_pkg::VIRT_PAGES - 1)) n_state = ptlru_pkg::S_IDLE;
            end
            ptlru_pkg::S_IDLE: begin
                if (acc) begin
                    case (i_req.func)
                        ptlru_pkg::FN_LOOKUP, ptlru_pkg::FN_MAP, ptlru_pkg::FN_DIRTY:
                            n_state = in_rng ? ptlru_pkg::S_LOOK : ptlru_pkg::S_OUT;
                        ptlru_pkg::FN_VICTIM:
                            n_state = (r_cnt == '0) ? ptlru_pkg::S_OUT : ptlru_pkg::S_VSEL;
                        default: n_state = ptlru_pkg::S_OUT;
                    endcase
                end
            end
            ptlru_pkg::S_LOOK: begin
                if ((r_func == ptlru_pkg::FN_MAP ||
                     (r_func == ptlru_pkg::FN_LOOKUP && ent_pres)) && r_cnt != '0)
                    n_state = ptlru_pkg::S_TRD;
                else
                    n_state = ptlru_pkg::S_OUT;
            end
            ptlru_pkg::S_TRD: n_state = ptlru_pkg::S_TCMP;
            ptlru_pkg::S_TCMP: begin
                if (i_rec_rdata == r_tf) n_state = ptlru_pkg::S_OUT;
                else if (last_pos)
                    n_state = (r_cnt != CW'(ptlru_pkg::FRAMES)) ? ptlru_pkg::S_TAPP
                                                                : ptlru_pkg::S_OUT;
                else n_state = ptlru_pkg::S_TRD;
            end
            ptlru_pkg::S_TAPP: n_state = ptlru_pkg::S_OUT;
            ptlru_pkg::S_VSEL: n_state = ptlru_pkg::S_PRD;
            ptlru_pkg::S_PRD:  n_state = ptlru_pkg::S_PCHK;
            ptlru_pkg::S_PCHK: begin
                if ((ent_pres && i_tbl_rdata[FW-1:0] == r_fo) ||
                    r_p == PW'(ptlru_pkg::VIRT_PAGES - 1))
                    n_state = ptlru_pkg::S_OUT;
                else
                    n_state = ptlru_pkg::S_PRD;
            end
            ptlru_pkg::S_OUT: begin
                if (!r_ovld || o_rsp.ready) n_state = ptlru_pkg::S_IDLE;
            end
            default: n_state = ptlru_pkg::S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_p = r_p; n_tf = r_tf; n_carry = r_carry; n_i = r_i; n_fo = r_fo; n_st = r_st;
        n_cnt = r_cnt; n_nff = r_nff; n_acc = r_acc; n_flt = r_flt; n_dflt = r_dflt;
        n_ovld = r_ovld && !o_rsp.ready;
        n_ofr = r_ofr; n_ost = r_ost; n_oacc = r_oacc; n_oflt = r_oflt; n_odflt = r_odflt;
        o_tbl = '{we: 1'b0, addr: r_p, wdata: '0};
        o_rec = '{we: 1'b0, addr: r_i, wdata: r_carry};
        case (r_state)
            ptlru_pkg::S_CLR: begin
                o_tbl.we = 1'b1;
                n_p      = r_p + PW'(1);
            end
            ptlru_pkg::S_IDLE: begin
                o_tbl.addr = i_req.address[ptlru_pkg::PAGE_SHIFT +: PW];
                if (acc) begin
                    n_p  = i_req.address[ptlru_pkg::PAGE_SHIFT +: PW];
                    n_fo = '0;
                    n_st = ptlru_pkg::ST_OK;
                    case (i_req.func)
                        ptlru_pkg::FN_LOOKUP: begin
                            n_acc = r_acc + SW'(1);
                            if (!in_rng) n_st = ptlru_pkg::ST_RANGE;
                        end
                        ptlru_pkg::FN_MAP, ptlru_pkg::FN_DIRTY: begin
                            if (!in_rng) n_st = ptlru_pkg::ST_RANGE;
                        end
                        ptlru_pkg::FN_FREE: begin
                            if (r_nff != CW'(ptlru_pkg::FRAMES)) begin
                                n_fo  = r_nff[FW-1:0];
                                n_nff = r_nff + CW'(1);
                            end else begin
                                n_st = ptlru_pkg::ST_NOFRAME;
                            end
                        end
                        ptlru_pkg::FN_VICTIM: begin
                            if (r_cnt == '0) begin
                                n_st = ptlru_pkg::ST_NOFRAME;
                            end else begin
                                n_cnt      = r_cnt - CW'(1);
                                o_rec.addr = FW'(r_cnt - CW'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ptlru_pkg::S_LOOK: begin
                o_tbl.addr = r_p;
                n_tf       = (r_func == ptlru_pkg::FN_MAP) ? r_frame : i_tbl_rdata[FW-1:0];
                n_carry    = n_tf;
                n_i        = '0;
                case (r_func)
                    ptlru_pkg::FN_LOOKUP: begin
                        if (ent_pres) begin
                            n_fo = i_tbl_rdata[FW-1:0];
                        end else begin
                            n_st  = ptlru_pkg::ST_FAULT;
                            n_flt = r_flt + SW'(1);
                            if (ent_dirty) n_dflt = r_dflt + SW'(1);
                        end
                    end
                    ptlru_pkg::FN_MAP: begin
                        o_tbl.we    = 1'b1;
                        o_tbl.wdata = {ent_dirty, 1'b1, r_frame};
                    end
                    default: begin
                        o_tbl.we    = 1'b1;
                        o_tbl.wdata = i_tbl_rdata | (ptlru_pkg::ENT_W'(1) << ptlru_pkg::ENT_DIRTY);
                    end
                endcase
                // empty list: the touched frame goes straight in
                if ((r_func == ptlru_pkg::FN_MAP || (r_func == ptlru_pkg::FN_LOOKUP && ent_pres))
                    && r_cnt == '0) begin
                    o_rec = '{we: 1'b1, addr: '0, wdata: n_tf};
                    n_cnt = CW'(1);
                end
            end
            ptlru_pkg::S_TCMP: begin
                o_rec.we = 1'b1;
                n_carry  = i_rec_rdata;
                n_i      = r_i + FW'(1);
            end
            ptlru_pkg::S_TAPP: begin
                o_rec = '{we: 1'b1, addr: FW'(r_cnt), wdata: r_carry};
                n_cnt = r_cnt + CW'(1);
            end
            ptlru_pkg::S_VSEL: begin
                n_fo = i_rec_rdata;
                n_p  = '0;
            end
            ptlru_pkg::S_PCHK: begin
                if (ent_pres && i_tbl_rdata[FW-1:0] == r_fo) begin
                    o_tbl.we    = 1'b1;
                    o_tbl.wdata = {2'b00, r_fo};
                end else begin
                    n_p = r_p + PW'(1);
                end
            end
            ptlru_pkg::S_OUT: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld = 1'b1; n_ofr = r_fo; n_ost = r_st;
                    n_oacc = r_acc; n_oflt = r_flt; n_odflt = r_dflt;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptlru_pkg::S_CLR;
            r_p     <= '0;
            r_cnt   <= '0;
            r_nff   <= '0;
            r_acc   <= '0;
            r_flt   <= '0;
            r_dflt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_cnt   <= n_cnt;
            r_nff   <= n_nff;
            r_acc   <= n_acc;
            r_flt   <= n_flt;
            r_dflt  <= n_dflt;
            r_ovld  <= n_ovld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_func  <= i_req.func;
            r_frame <= i_req.frame;
        end
        r_tf <= n_tf; r_carry <= n_carry; r_i <= n_i; r_fo <= n_fo; r_st <= n_st;
        r_ofr <= n_ofr; r_ost <= n_ost; r_oacc <= n_oacc; r_oflt <= n_oflt;
        r_odflt <= n_odflt;
    end

    assign o_rsp.valid             = r_ovld;
    assign o_rsp.frame_out         = r_ofr;
    assign o_rsp.status            = r_ost;
    assign o_rsp.total_accesses    = r_oacc;
    assign o_rsp.fault_count       = r_oflt;
    assign o_rsp.dirty_fault_count = r_odflt;

    `PTLRU_ASSERT_NOW(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(ptlru_pkg::FRAMES))
    `PTLRU_ASSERT_NOW(a_nff_max, i_clk, i_rst_n, 1'b1, r_nff <= CW'(ptlru_pkg::FRAMES))
    `PTLRU_ASSERT_NOW(a_clr_zero, i_clk, i_rst_n, r_state == ptlru_pkg::S_CLR,
                      o_tbl.we && o_tbl.wdata == '0 && !i_req.ready)
    `PTLRU_ASSERT_NEXT(a_out_load, i_clk, i_rst_n,
                       r_state == ptlru_pkg::S_OUT && (!r_ovld || o_rsp.ready),
                       r_ovld && r_state == ptlru_pkg::S_IDLE)
endmodule

### rtl/page_table_lru_frame_manager.sv
// Top level: page table with LRU frame replacement.
// Depends on ptlru_pkg, ptlru_if, ptlru_ram and ptlru_ctrl.
//
//   channel  | dir | beat fields
//   ---------+-----+-------------------------------------------------------
//   i_req    | in  | func, address, frame
//   o_rsp    | out | frame_out, status, total_accesses, fault_count,
//            |     | dirty_fault_count
//
// After reset a clearing pass writes all 16384 table entries, one a cycle;
// no request is taken until the pass is done. Hit and map walk the recency
// list position by position (read, then write back); lookup miss, mark
// dirty and free frame skip the walk. Victim scans the table page by page.
// One request is in flight at a time; the response register lets the next
// request in while a beat waits.
module page_table_lru_frame_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptlru_req_if.sink   i_req,
    ptlru_rsp_if.source o_rsp
);
    ptlru_pkg::t_tbl_port          tbl;
    ptlru_pkg::t_rec_port          rec;
    logic [ptlru_pkg::ENT_W-1:0]   tbl_rdata;
    logic [ptlru_pkg::FRAME_W-1:0] rec_rdata;

    // page table entries
    ptlru_ram #(.DEPTH(ptlru_pkg::VIRT_PAGES), .WIDTH(ptlru_pkg::ENT_W)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl.we),
        .i_addr  (tbl.addr),
        .i_wdata (tbl.wdata),
        .o_rdata (tbl_rdata)
    );

    // recency list, most recent at position zero
    ptlru_ram #(.DEPTH(ptlru_pkg::FRAMES), .WIDTH(ptlru_pkg::FRAME_W)) u_rec (
        .i_clk   (i_clk),
        .i_we    (rec.we),
        .i_addr  (rec.addr),
        .i_wdata (rec.wdata),
        .o_rdata (rec_rdata)
    );

    ptlru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_tbl_rdata (tbl_rdata),
        .i_rec_rdata (rec_rdata),
        .o_tbl       (tbl),
        .o_rec       (rec)
    );
endmodule
